@@ rtl/slpr_pkg.sv @@
// Shared types and constants for the SAM line position router.
// Used by sam_line_position_router, slpr_front and slpr_back; depends on nothing.
package slpr_pkg;

   localparam int POS_W  = 40;
   localparam int DIV_W  = 41;
   localparam int SINK_W = 17;
   localparam int CSR_W  = 11;
   localparam logic [POS_W-1:0] POS_MAX = 40'hFF_FFFF_FFFF;

   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_Q     = 8'h51;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [1:0] KIND_REF = 2'd0;
   localparam logic [1:0] KIND_HDR = 2'd1;
   localparam logic [1:0] KIND_ALN = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_OVF     = 2'd3;

   typedef enum logic [1:0] {MODE_NONE, MODE_NAME, MODE_NUM} tok_mode_type;

   typedef struct packed {
      logic             header;
      logic             sq;
      logic             end_hdr;
      logic             ovf;
      logic [POS_W-1:0] number;
   } line_desc_type;

   typedef enum logic [3:0] {
      B_IDLE, B_WDIV_START, B_WDIV_WAIT, B_DISPATCH, B_HDR_INC, B_HDR_ADD,
      B_LOOK_RD, B_LOOK_CMP, B_POS_ADD, B_SDIV_START, B_SDIV_WAIT, B_EMIT
   } back_state_type;

endpackage

@@ rtl/sam_line_position_router.sv @@
// SAM line position router. Bytes are taken at one per cycle while the line queue has room;
// a result follows each newline. An alignment line waits on the table search, which reads
// and compares one entry at a time, and on the 41-step divider; the first alignment line
// also runs the sink width division.
// A two-entry line queue lets parsing continue while the back end works on earlier lines.
// Synchronous active-high reset clears control state; the reference table needs no clearing.
module sam_line_position_router #(
   parameter int MAX_REFS   = 128,
   parameter int NAME_BYTES = 32,
   parameter int MAX_SINKS  = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_text_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_line_kind,
   output logic [9:0]                   rsp_sink_index,
   output logic [slpr_pkg::POS_W-1:0]   rsp_global_position,
   output logic [1:0]                   rsp_line_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [slpr_pkg::CSR_W-1:0]   csr_sink_count
);
   localparam int LW = $clog2(NAME_BYTES + 1);
   localparam int NW = NAME_BYTES * 8;
   localparam int QW = $bits(slpr_pkg::line_desc_type) + LW + NW;

   logic [slpr_pkg::CSR_W-1:0] sink_count_ff;

   logic                    push, pop, q_not_empty, q_not_full;
   slpr_pkg::line_desc_type f_desc, q_desc;
   logic [NW-1:0]           f_name, q_name;
   logic [LW-1:0]           f_nlen, q_nlen;
   logic [QW-1:0]           q_rdata;

   assign csr_ready = 1'b1;
   assign req_ready = q_not_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         sink_count_ff <= slpr_pkg::CSR_W'(1);
      end else if (csr_valid && csr_ready) begin
         sink_count_ff <= csr_sink_count;
      end
   end

   slpr_front #(.NAME_BYTES(NAME_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_valid),
      .byte_ready (req_ready),
      .text_byte  (req_text_byte),
      .push       (push),
      .desc       (f_desc),
      .name       (f_name),
      .name_len   (f_nlen)
   );

   slpr_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wdata     ({f_desc, f_nlen, f_name}),
      .pop       (pop),
      .not_empty (q_not_empty),
      .not_full  (q_not_full),
      .rdata     (q_rdata)
   );

   assign {q_desc, q_nlen, q_name} = q_rdata;

   slpr_back #(
      .MAX_REFS   (MAX_REFS),
      .NAME_BYTES (NAME_BYTES),
      .MAX_SINKS  (MAX_SINKS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_not_empty),
      .q_desc              (q_desc),
      .q_name              (q_name),
      .q_nlen              (q_nlen),
      .q_pop               (pop),
      .sink_count          (sink_count_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_line_kind       (rsp_line_kind),
      .rsp_sink_index      (rsp_sink_index),
      .rsp_global_position (rsp_global_position),
      .rsp_line_status     (rsp_line_status)
   );
endmodule

@@ rtl/slpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module slpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/slpr_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module slpr_div #(
   parameter int W = 41
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W:0]    rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_sh  = {rem_ff[W-1:0], quo_ff[W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sh - {1'b0, dsr_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ rtl/slpr_front.sv @@
// Byte parser: tracks header and alignment fields, emits one line word per newline.
// Depends on slpr_pkg.
module slpr_front #(
   parameter int NAME_BYTES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                byte_valid,
   input  logic                                byte_ready,
   input  logic [7:0]                          text_byte,
   output logic                                push,
   output slpr_pkg::line_desc_type             desc,
   output logic [NAME_BYTES*8-1:0]             name,
   output logic [$clog2(NAME_BYTES+1)-1:0]     name_len
);
   localparam int LW = $clog2(NAME_BYTES + 1);
   localparam int NW = NAME_BYTES * 8;

   logic                      in_header_ff, in_header_in;
   logic                      started_ff, started_in;
   logic                      hdr_ff, hdr_in;
   logic                      sq_ff, sq_in;
   logic                      endh_ff, endh_in;
   logic [1:0]                col_ff, col_in;
   logic [1:0]                tcol_ff, tcol_in;
   logic [7:0]                pre0_ff, pre0_in;
   logic [7:0]                pre1_ff, pre1_in;
   slpr_pkg::tok_mode_type    mode_ff, mode_in;
   logic [3:0]                field_ff, field_in;
   logic [NW-1:0]             name_ff, name_in;
   logic [LW-1:0]             nlen_ff, nlen_in;
   logic [slpr_pkg::POS_W-1:0] num_ff, num_in;
   logic                      ovf_ff, ovf_in;

   logic                      fire, first, hdr_now, endh_now, ws, do_feed;
   logic [3:0]                field_nx;
   logic [slpr_pkg::POS_W+3:0] prod;
   logic [7:0]                c;

   always_comb begin
      c        = text_byte;
      fire     = byte_valid & byte_ready;
      first    = !started_ff;
      hdr_now  = first ? (in_header_ff && c == slpr_pkg::CH_AT) : hdr_ff;
      endh_now = first ? (in_header_ff && c != slpr_pkg::CH_AT) : endh_ff;
      ws       = (c == slpr_pkg::CH_SP) || (c == slpr_pkg::CH_TAB) || (c == slpr_pkg::CH_VT) ||
                 (c == slpr_pkg::CH_FF) || (c == slpr_pkg::CH_CR);
      prod     = ({4'b0, num_ff} << 3) + ({4'b0, num_ff} << 1) +
                 {{(slpr_pkg::POS_W){1'b0}}, 4'(c - slpr_pkg::CH_ZERO)};
      field_nx = (field_ff < 4'd15) ? field_ff + 4'd1 : field_ff;

      in_header_in = in_header_ff;
      started_in   = started_ff;
      hdr_in       = hdr_ff;
      sq_in        = sq_ff;
      endh_in      = endh_ff;
      col_in       = col_ff;
      tcol_in      = tcol_ff;
      pre0_in      = pre0_ff;
      pre1_in      = pre1_ff;
      mode_in      = mode_ff;
      field_in     = field_ff;
      name_in      = name_ff;
      nlen_in      = nlen_ff;
      num_in       = num_ff;
      ovf_in       = ovf_ff;
      push         = 1'b0;
      do_feed      = 1'b0;

      if (fire) begin
         started_in = 1'b1;
         hdr_in     = hdr_now;
         endh_in    = endh_now;
         if (first) begin
            sq_in = hdr_now;
            if (in_header_ff && c != slpr_pkg::CH_AT) begin
               in_header_in = 1'b0;
            end
         end
         if (c == slpr_pkg::CH_NL) begin
            push       = 1'b1;
            started_in = 1'b0;
            hdr_in     = 1'b0;
            sq_in      = 1'b0;
            endh_in    = 1'b0;
            col_in     = '0;
            tcol_in    = '0;
            mode_in    = slpr_pkg::MODE_NONE;
            field_in   = '0;
            name_in    = '0;
            nlen_in    = '0;
            num_in     = '0;
            ovf_in     = 1'b0;
         end else begin
            if (hdr_now) begin
               if (col_ff == 2'd1 && c != slpr_pkg::CH_S) begin
                  sq_in = 1'b0;
               end
               if (col_ff == 2'd2 && c != slpr_pkg::CH_Q) begin
                  sq_in = 1'b0;
               end
               if (ws) begin
                  tcol_in = '0;
                  mode_in = slpr_pkg::MODE_NONE;
               end else if (tcol_ff < 2'd3) begin
                  if (tcol_ff == 2'd0) begin
                     pre0_in = c;
                  end
                  if (tcol_ff == 2'd1) begin
                     pre1_in = c;
                  end
                  tcol_in = tcol_ff + 2'd1;
                  if (tcol_ff == 2'd2 && c == slpr_pkg::CH_COLON) begin
                     if (pre0_ff == slpr_pkg::CH_S && pre1_ff == slpr_pkg::CH_N) begin
                        mode_in = slpr_pkg::MODE_NAME;
                        name_in = '0;
                        nlen_in = '0;
                     end else if (pre0_ff == slpr_pkg::CH_L && pre1_ff == slpr_pkg::CH_N) begin
                        mode_in = slpr_pkg::MODE_NUM;
                        num_in  = '0;
                     end
                  end
               end else begin
                  do_feed = 1'b1;
               end
            end else begin
               if (c == slpr_pkg::CH_TAB) begin
                  field_in = field_nx;
                  if (field_nx == 4'd2) begin
                     mode_in = slpr_pkg::MODE_NAME;
                  end else if (field_nx == 4'd3) begin
                     mode_in = slpr_pkg::MODE_NUM;
                  end else begin
                     mode_in = slpr_pkg::MODE_NONE;
                  end
               end else begin
                  do_feed = 1'b1;
               end
            end
            if (col_ff < 2'd3) begin
               col_in = col_ff + 2'd1;
            end
         end
      end

      if (do_feed) begin
         if (mode_ff == slpr_pkg::MODE_NAME) begin
            if (nlen_ff < LW'(NAME_BYTES)) begin
               for (int k = 0; k < NAME_BYTES; k++) begin
                  if (nlen_ff == LW'(k)) begin
                     name_in[k*8 +: 8] = c;
                  end
               end
               nlen_in = nlen_ff + 1'b1;
            end
         end else if (mode_ff == slpr_pkg::MODE_NUM) begin
            if (c >= slpr_pkg::CH_ZERO && c <= slpr_pkg::CH_NINE) begin
               if (prod > {4'b0, slpr_pkg::POS_MAX}) begin
                  num_in = slpr_pkg::POS_MAX;
                  ovf_in = 1'b1;
               end else begin
                  num_in = prod[slpr_pkg::POS_W-1:0];
               end
            end else begin
               mode_in = slpr_pkg::MODE_NONE;
            end
         end
      end

      desc.header  = hdr_now;
      desc.sq      = first ? hdr_now : sq_ff;
      desc.end_hdr = endh_now;
      desc.ovf     = ovf_ff;
      desc.number  = num_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff <= 1'b1;
         started_ff   <= 1'b0;
         hdr_ff       <= 1'b0;
         sq_ff        <= 1'b0;
         endh_ff      <= 1'b0;
         col_ff       <= '0;
         tcol_ff      <= '0;
         pre0_ff      <= '0;
         pre1_ff      <= '0;
         mode_ff      <= slpr_pkg::MODE_NONE;
         field_ff     <= '0;
         name_ff      <= '0;
         nlen_ff      <= '0;
         num_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         in_header_ff <= in_header_in;
         started_ff   <= started_in;
         hdr_ff       <= hdr_in;
         sq_ff        <= sq_in;
         endh_ff      <= endh_in;
         col_ff       <= col_in;
         tcol_ff      <= tcol_in;
         pre0_ff      <= pre0_in;
         pre1_ff      <= pre1_in;
         mode_ff      <= mode_in;
         field_ff     <= field_in;
         name_ff      <= name_in;
         nlen_ff      <= nlen_in;
         num_ff       <= num_in;
         ovf_ff       <= ovf_in;
      end
   end

   assign name     = name_ff;
   assign name_len = nlen_ff;
endmodule

@@ rtl/slpr_queue.sv @@
// Two-entry queue of line words between parser and back end.
// Depends on nothing.
module slpr_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   input  logic         pop,
   output logic         not_empty,
   output logic         not_full,
   output logic [W-1:0] rdata
);
   logic [W-1:0] slot_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         slot_ff[wp_ff] <= wdata;
      end
   end

   assign not_empty = (cnt_ff != 2'd0);
   assign not_full  = (cnt_ff != 2'd2);
   assign rdata     = slot_ff[rp_ff];
endmodule

@@ rtl/slpr_back.sv @@
// Back end: reference table, name lookup, width and sink division, result register.
// Depends on slpr_pkg, slpr_ram, slpr_div.
module slpr_back #(
   parameter int MAX_REFS   = 128,
   parameter int NAME_BYTES = 32,
   parameter int MAX_SINKS  = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  slpr_pkg::line_desc_type             q_desc,
   input  logic [NAME_BYTES*8-1:0]             q_name,
   input  logic [$clog2(NAME_BYTES+1)-1:0]     q_nlen,
   output logic                                q_pop,
   input  logic [slpr_pkg::CSR_W-1:0]          sink_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_line_kind,
   output logic [9:0]                          rsp_sink_index,
   output logic [slpr_pkg::POS_W-1:0]          rsp_global_position,
   output logic [1:0]                          rsp_line_status
);
   localparam int LW = $clog2(NAME_BYTES + 1);
   localparam int NW = NAME_BYTES * 8;
   localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CW = $clog2(MAX_REFS + 1);
   localparam int RW = LW + slpr_pkg::POS_W + NW;
   localparam int PW = slpr_pkg::POS_W;
   localparam int DW = slpr_pkg::DIV_W;
   localparam int SW = slpr_pkg::SINK_W;

   slpr_pkg::back_state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [PW-1:0] total_ff, total_in;
   logic [PW-1:0] width_ff, width_in;
   logic [PW-1:0] gpos_ff, gpos_in;
   logic [PW-1:0] inc_ff, inc_in;
   logic          ovf_ff, ovf_in;
   logic [1:0]    kind_ff, kind_in;
   logic [1:0]    status_ff, status_in;
   logic [9:0]    sink_ff, sink_in;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_kind_ff, out_kind_in;
   logic [9:0]    out_sink_ff, out_sink_in;
   logic [PW-1:0] out_gpos_ff, out_gpos_in;
   logic [1:0]    out_status_ff, out_status_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [RW-1:0] ram_wdata, ram_rdata;
   logic          div_start, div_done;
   logic [DW-1:0] div_a, div_b, div_q;

   logic [SW-1:0] eff_s;
   logic [DW-1:0] eff_m1;
   logic [PW:0]   sum;
   logic          match, unmapped, slot_free;

   slpr_ram #(.WIDTH(RW), .DEPTH(MAX_REFS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   slpr_div #(.W(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      if (sink_count == '0) begin
         eff_s = SW'(1);
      end else if ({{(SW-slpr_pkg::CSR_W){1'b0}}, sink_count} > SW'(MAX_SINKS)) begin
         eff_s = SW'(MAX_SINKS);
      end else begin
         eff_s = {{(SW-slpr_pkg::CSR_W){1'b0}}, sink_count};
      end
      eff_m1    = {{(DW-SW){1'b0}}, eff_s - SW'(1)};
      unmapped  = ((q_nlen != '0) && (q_name[7:0] == slpr_pkg::CH_STAR)) ||
                  (q_desc.number == '0);
      match     = (ram_rdata[RW-1 -: LW] == q_nlen) && (ram_rdata[NW-1:0] == q_name);
      slot_free = !out_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slpr_pkg::B_IDLE: begin
            if (q_valid) begin
               state_in = q_desc.end_hdr ? slpr_pkg::B_WDIV_START : slpr_pkg::B_DISPATCH;
            end
         end
         slpr_pkg::B_WDIV_START: state_in = slpr_pkg::B_WDIV_WAIT;
         slpr_pkg::B_WDIV_WAIT: begin
            if (div_done) begin
               state_in = slpr_pkg::B_DISPATCH;
            end
         end
         slpr_pkg::B_DISPATCH: begin
            if (q_desc.header) begin
               state_in = q_desc.sq ? slpr_pkg::B_HDR_INC : slpr_pkg::B_EMIT;
            end else if (unmapped) begin
               state_in = (width_ff != '0) ? slpr_pkg::B_SDIV_START : slpr_pkg::B_EMIT;
            end else if (count_ff == '0) begin
               state_in = slpr_pkg::B_EMIT;
            end else begin
               state_in = slpr_pkg::B_LOOK_RD;
            end
         end
         slpr_pkg::B_HDR_INC: state_in = slpr_pkg::B_HDR_ADD;
         slpr_pkg::B_HDR_ADD: state_in = slpr_pkg::B_EMIT;
         slpr_pkg::B_LOOK_RD: state_in = slpr_pkg::B_LOOK_CMP;
         slpr_pkg::B_LOOK_CMP: begin
            if (match) begin
               state_in = slpr_pkg::B_POS_ADD;
            end else if (idx_ff == '0) begin
               state_in = slpr_pkg::B_EMIT;
            end else begin
               state_in = slpr_pkg::B_LOOK_RD;
            end
         end
         slpr_pkg::B_POS_ADD: begin
            state_in = (width_ff != '0) ? slpr_pkg::B_SDIV_START : slpr_pkg::B_EMIT;
         end
         slpr_pkg::B_SDIV_START: state_in = slpr_pkg::B_SDIV_WAIT;
         slpr_pkg::B_SDIV_WAIT: begin
            if (div_done) begin
               state_in = slpr_pkg::B_EMIT;
            end
         end
         slpr_pkg::B_EMIT: begin
            if (slot_free) begin
               state_in = slpr_pkg::B_IDLE;
            end
         end
         default: state_in = slpr_pkg::B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      total_in      = total_ff;
      width_in      = width_ff;
      gpos_in       = gpos_ff;
      inc_in        = inc_ff;
      ovf_in        = ovf_ff;
      kind_in       = kind_ff;
      status_in     = status_ff;
      sink_in       = sink_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_sink_in   = out_sink_ff;
      out_gpos_in   = out_gpos_ff;
      out_status_in = out_status_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[AW-1:0];
      ram_wdata     = {q_nlen, total_ff, q_name};
      ram_raddr     = AW'(idx_ff - 1'b1);
      div_start     = 1'b0;
      div_a         = {1'b0, gpos_ff};
      div_b         = {1'b0, width_ff};
      sum           = {1'b0, total_ff} + {1'b0, inc_ff};

      case (state_ff)
         slpr_pkg::B_IDLE: begin
            ovf_in  = q_desc.ovf;
            sink_in = '0;
         end
         slpr_pkg::B_WDIV_START: begin
            div_start = 1'b1;
            div_a     = {1'b0, total_ff} + {{(DW-SW){1'b0}}, eff_s};
            div_b     = {{(DW-SW){1'b0}}, eff_s};
         end
         slpr_pkg::B_WDIV_WAIT: begin
            if (div_done) begin
               width_in = div_q[DW-1] ? slpr_pkg::POS_MAX : div_q[PW-1:0];
            end
         end
         slpr_pkg::B_DISPATCH: begin
            status_in = slpr_pkg::ST_OK;
            gpos_in   = '0;
            if (q_desc.header) begin
               if (q_desc.sq) begin
                  kind_in = slpr_pkg::KIND_REF;
                  gpos_in = total_ff;
                  if (count_ff < CW'(MAX_REFS)) begin
                     ram_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     status_in = slpr_pkg::ST_FULL;
                  end
               end else begin
                  kind_in = slpr_pkg::KIND_HDR;
               end
            end else begin
               kind_in = slpr_pkg::KIND_ALN;
               idx_in  = count_ff;
               if (unmapped) begin
                  gpos_in   = total_ff;
                  status_in = q_desc.ovf ? slpr_pkg::ST_OVF : slpr_pkg::ST_OK;
               end else if (count_ff == '0) begin
                  status_in = slpr_pkg::ST_UNKNOWN;
               end
            end
         end
         slpr_pkg::B_HDR_INC: begin
            if (q_desc.number == slpr_pkg::POS_MAX) begin
               inc_in = slpr_pkg::POS_MAX;
               ovf_in = 1'b1;
            end else begin
               inc_in = q_desc.number + 1'b1;
            end
         end
         slpr_pkg::B_HDR_ADD: begin
            if (sum[PW]) begin
               total_in = slpr_pkg::POS_MAX;
            end else begin
               total_in = sum[PW-1:0];
            end
            if (status_ff == slpr_pkg::ST_OK && (ovf_ff || sum[PW])) begin
               status_in = slpr_pkg::ST_OVF;
            end
         end
         slpr_pkg::B_LOOK_RD: begin
            idx_in = idx_ff - 1'b1;
         end
         slpr_pkg::B_LOOK_CMP: begin
            ram_raddr = AW'(idx_ff - 1'b1);
            if (match) begin
               gpos_in = ram_rdata[NW +: PW];
            end else if (idx_ff == '0) begin
               status_in = slpr_pkg::ST_UNKNOWN;
            end
         end
         slpr_pkg::B_POS_ADD: begin
            sum = {1'b0, gpos_ff} + {1'b0, q_desc.number};
            if (sum[PW]) begin
               gpos_in = slpr_pkg::POS_MAX;
            end else begin
               gpos_in = sum[PW-1:0];
            end
            status_in = (ovf_ff || sum[PW]) ? slpr_pkg::ST_OVF : slpr_pkg::ST_OK;
         end
         slpr_pkg::B_SDIV_START: begin
            div_start = 1'b1;
         end
         slpr_pkg::B_SDIV_WAIT: begin
            if (div_done) begin
               // clamp to the last sink
               sink_in = (div_q > eff_m1) ? eff_m1[9:0] : div_q[9:0];
            end
         end
         slpr_pkg::B_EMIT: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = kind_ff;
               out_sink_in   = sink_ff;
               out_gpos_in   = gpos_ff;
               out_status_in = status_ff;
               q_pop         = 1'b1;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slpr_pkg::B_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         width_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         width_ff     <= width_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff        <= idx_in;
      gpos_ff       <= gpos_in;
      inc_ff        <= inc_in;
      ovf_ff        <= ovf_in;
      kind_ff       <= kind_in;
      status_ff     <= status_in;
      sink_ff       <= sink_in;
      out_kind_ff   <= out_kind_in;
      out_sink_ff   <= out_sink_in;
      out_gpos_ff   <= out_gpos_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_line_kind       = out_kind_ff;
   assign rsp_sink_index      = out_sink_ff;
   assign rsp_global_position = out_gpos_ff;
   assign rsp_line_status     = out_status_ff;
endmodule

@@ sim/sam_line_position_router_test.sv @@
// Self-checking testbench for sam_line_position_router: feeds SAM text byte by byte,
// predicts each line's word and compares it field by field at the result port.
// Depends on rtl/slpr_pkg.sv and rtl/sam_line_position_router.sv.
module sam_line_position_router_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REFS        = 128;
   localparam int HDR_REFS    = 16;
   localparam int NB          = 32;
   localparam int SINKS       = 1024;
   localparam int SETTLE      = 400;
   localparam int HOLD_LEN    = 1500;
   localparam int QUIET_LIMIT = 10000;
   localparam int HOLD_AT     = 12;

   typedef struct {
      logic [1:0]                 kind;
      logic [9:0]                 sink;
      logic [slpr_pkg::POS_W-1:0] gpos;
      logic [1:0]                 status;
   } line_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_text_byte = 8'd0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_line_kind;
   logic [9:0]                 rsp_sink_index;
   logic [slpr_pkg::POS_W-1:0] rsp_global_position;
   logic [1:0]                 rsp_line_status;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [slpr_pkg::CSR_W-1:0] csr_sink_count = '0;

   sam_line_position_router uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_text_byte(req_text_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_line_kind(rsp_line_kind),
      .rsp_sink_index(rsp_sink_index), .rsp_global_position(rsp_global_position),
      .rsp_line_status(rsp_line_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_sink_count(csr_sink_count)
   );

   always #1 clock = ~clock;

   bit [7:0]        text_q[$];
   line_result_type line_results[$];
   int              errors = 0;
   bit              gaps_on = 1'b1;

   // ---------------- line predictor ----------------
   bit [NB*8-1:0]   ref_names [REFS];
   int unsigned     ref_lens [REFS];
   longint unsigned ref_offsets [REFS];
   int unsigned     n_refs = 0;
   longint unsigned total_len = 0;
   longint unsigned width_div = 0;
   bit              hdr_phase = 1'b1;
   int unsigned     sinks_cfg = 1;
   int unsigned     fld = 0, col = 0, tcol = 0, nlen = 0;
   bit [NB*8-1:0]   nbuf = '0;
   longint unsigned acc = 0;
   bit              started = 0, is_hdr = 0, is_sq = 0, ovf = 0;
   bit [7:0]        pfx [3];
   slpr_pkg::tok_mode_type mode = slpr_pkg::MODE_NONE;

   function longint unsigned sat_add(longint unsigned a, longint unsigned b);
      longint unsigned r;
      r = a + b;
      if (r > slpr_pkg::POS_MAX) begin
         r = slpr_pkg::POS_MAX;
         ovf = 1'b1;
      end
      return r;
   endfunction

   function longint unsigned active_sinks();
      if (sinks_cfg == 0) return 1;
      if (sinks_cfg > SINKS) return SINKS;
      return sinks_cfg;
   endfunction

   function void take_field_byte(bit [7:0] c);
      if (mode == slpr_pkg::MODE_NAME) begin
         if (nlen < NB) begin
            nbuf[nlen*8 +: 8] = c;
            nlen++;
         end
      end else if (mode == slpr_pkg::MODE_NUM) begin
         if (c >= slpr_pkg::CH_ZERO && c <= slpr_pkg::CH_NINE)
            acc = sat_add(acc * 10, c - slpr_pkg::CH_ZERO);
         else mode = slpr_pkg::MODE_NONE;
      end
   endfunction

   function void close_line();
      line_result_type r;
      longint unsigned g, s, sink;
      int              i, idx;
      bit              hit;
      r.kind = slpr_pkg::KIND_HDR;
      r.status = slpr_pkg::ST_OK;
      g = 0;
      sink = 0;
      if (is_hdr) begin
         if (is_sq) begin
            r.kind = slpr_pkg::KIND_REF;
            g = total_len;
            if (n_refs < REFS) begin
               ref_names[n_refs] = nbuf;
               ref_lens[n_refs] = nlen;
               ref_offsets[n_refs] = total_len;
               n_refs++;
            end else begin
               r.status = slpr_pkg::ST_FULL;
            end
            total_len = sat_add(total_len, sat_add(acc, 1));
            if (r.status == slpr_pkg::ST_OK && ovf) r.status = slpr_pkg::ST_OVF;
         end
      end else begin
         r.kind = slpr_pkg::KIND_ALN;
         hit = 1'b1;
         if ((nlen > 0 && nbuf[7:0] == slpr_pkg::CH_STAR) || acc == 0) begin
            g = total_len;
         end else begin
            hit = 1'b0;
            idx = 0;
            // newest entry wins on duplicate names
            for (i = int'(n_refs) - 1; i >= 0 && !hit; i--)
               if (ref_lens[i] == nlen && ref_names[i] == nbuf) begin
                  hit = 1'b1;
                  idx = i;
               end
            if (hit) g = sat_add(ref_offsets[idx], acc);
         end
         if (!hit) begin
            r.status = slpr_pkg::ST_UNKNOWN;
         end else begin
            s = active_sinks();
            sink = width_div != 0 ? g / width_div : 0;
            if (sink > s - 1) sink = s - 1;
            if (ovf) r.status = slpr_pkg::ST_OVF;
         end
      end
      r.sink = sink[9:0];
      r.gpos = g[slpr_pkg::POS_W-1:0];
      line_results.push_back(r);
   endfunction

   function void route_byte(bit [7:0] c);
      longint unsigned s, w;
      if (!started) begin
         started = 1'b1;
         if (hdr_phase && c == slpr_pkg::CH_AT) begin
            is_hdr = 1'b1;
            is_sq = 1'b1;
         end else if (hdr_phase) begin
            s = active_sinks();
            w = (total_len + s) / s;
            width_div = w > slpr_pkg::POS_MAX ? slpr_pkg::POS_MAX : w;
            hdr_phase = 1'b0;
         end
      end
      if (c == slpr_pkg::CH_NL) begin
         close_line();
         fld = 0; col = 0; tcol = 0; nlen = 0; nbuf = '0; acc = 0;
         started = 0; is_hdr = 0; is_sq = 0; ovf = 0; mode = slpr_pkg::MODE_NONE;
         return;
      end
      if (is_hdr) begin
         if ((col == 1 && c != slpr_pkg::CH_S) || (col == 2 && c != slpr_pkg::CH_Q))
            is_sq = 1'b0;
         if (c == slpr_pkg::CH_SP || c == slpr_pkg::CH_TAB || c == slpr_pkg::CH_VT ||
             c == slpr_pkg::CH_FF || c == slpr_pkg::CH_CR) begin
            tcol = 0;
            mode = slpr_pkg::MODE_NONE;
         end else if (tcol < 3) begin
            pfx[tcol] = c;
            tcol++;
            if (tcol == 3 && pfx[2] == slpr_pkg::CH_COLON) begin
               if (pfx[0] == slpr_pkg::CH_S && pfx[1] == slpr_pkg::CH_N) begin
                  mode = slpr_pkg::MODE_NAME;
                  nlen = 0;
                  nbuf = '0;
               end else if (pfx[0] == slpr_pkg::CH_L && pfx[1] == slpr_pkg::CH_N) begin
                  mode = slpr_pkg::MODE_NUM;
                  acc = 0;
               end
            end
         end else begin
            take_field_byte(c);
         end
      end else if (c == slpr_pkg::CH_TAB) begin
         if (fld < 15) fld++;
         mode = fld == 2 ? slpr_pkg::MODE_NAME :
                fld == 3 ? slpr_pkg::MODE_NUM : slpr_pkg::MODE_NONE;
      end else begin
         take_field_byte(c);
      end
      if (col < 3) col++;
   endfunction

   // ---------------- driver ----------------
   int feed_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         feed_gap = 0;
      end else begin
         if (req_valid && req_ready) route_byte(req_text_byte);
         if (!req_valid || req_ready) begin
            if (feed_gap > 0) begin
               feed_gap--;
               req_valid <= 1'b0;
            end else if (text_q.size() != 0) begin
               req_valid <= 1'b1;
               req_text_byte <= text_q.pop_front();
               feed_gap = gaps_on ? $urandom_range(0, 6) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   task automatic report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   int drain_hold = 0;
   int words_seen = 0;
   always @(posedge clock) begin
      line_result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         drain_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (line_results.size() == 0) begin
               report("unexpected word, kind", rsp_line_kind, 0);
            end else begin
               e = line_results.pop_front();
               if (rsp_line_kind !== e.kind) report("line_kind", rsp_line_kind, e.kind);
               if (rsp_sink_index !== e.sink) report("sink_index", rsp_sink_index, e.sink);
               if (rsp_global_position !== e.gpos)
                  report("global_position", rsp_global_position, e.gpos);
               if (rsp_line_status !== e.status)
                  report("line_status", rsp_line_status, e.status);
            end
            // hold off long once so the line queue fills and input stalls
            if (words_seen == HOLD_AT) drain_hold = HOLD_LEN;
            else drain_hold = gaps_on ? $urandom_range(0, 6) : 0;
         end
         if (drain_hold > 0) begin
            drain_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------
   int quiet = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ---------------- text generation ----------------
   bit [319:0] known_names[$];
   int         known_lens[$];

   function automatic void push_s(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic void push_dec(longint unsigned v);
      push_s($sformatf("%0d", v));
   endfunction

   function automatic bit [7:0] noise_byte();
      bit [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == slpr_pkg::CH_NL);
      return b;
   endfunction

   function automatic bit [7:0] name_byte();
      bit [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b == slpr_pkg::CH_TAB || b == slpr_pkg::CH_NL || b == slpr_pkg::CH_VT ||
             b == slpr_pkg::CH_FF || b == slpr_pkg::CH_CR || b == slpr_pkg::CH_SP ||
             b == slpr_pkg::CH_STAR);
      return b;
   endfunction

   function automatic void push_name(bit [319:0] nm, int n);
      for (int i = 0; i < n; i++) text_q.push_back(nm[i*8 +: 8]);
   endfunction

   function automatic void random_name(output bit [319:0] nm, output int n);
      nm = '0;
      n = $urandom_range(0, 9) == 0 ? $urandom_range(33, 40) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) nm[i*8 +: 8] = name_byte();
   endfunction

   function automatic bit [7:0] header_sep();
      case ($urandom_range(0, 5))
         0: return slpr_pkg::CH_SP;
         1: return slpr_pkg::CH_VT;
         2: return slpr_pkg::CH_FF;
         3: return slpr_pkg::CH_CR;
         default: return slpr_pkg::CH_TAB;
      endcase
   endfunction

   function automatic void sq_line(bit [319:0] nm, int n, string len_text);
      push_s("@SQ");
      text_q.push_back(header_sep());
      push_s("SN:");
      push_name(nm, n);
      text_q.push_back(header_sep());
      push_s("LN:");
      push_s(len_text);
      text_q.push_back(slpr_pkg::CH_NL);
      known_names.push_back(nm);
      known_lens.push_back(n);
   endfunction

   function automatic string rand_pos();
      longint unsigned v;
      if ($urandom_range(0, 3) == 0) v = {$urandom, $urandom} & slpr_pkg::POS_MAX;
      else v = $urandom_range(1, 32'h7FFF_FFFF);
      return $sformatf("%0d", v);
   endfunction

   function automatic void align_line(int pick);
      bit [319:0] nm;
      int         n, k;
      if (pick == 9) begin
         case ($urandom_range(0, 4))
            0: ;
            1: push_s("q\tf");
            2: push_s("q");
            3: for (int i = 0; i < 20; i++) text_q.push_back(slpr_pkg::CH_TAB);
            default: repeat ($urandom_range(1, 30)) text_q.push_back(noise_byte());
         endcase
         text_q.push_back(slpr_pkg::CH_NL);
         return;
      end
      repeat ($urandom_range(1, 6)) text_q.push_back(name_byte());
      push_s("\t");
      push_dec($urandom_range(0, 4095));
      push_s("\t");
      k = $urandom_range(0, known_names.size() - 1);
      case (pick)
         5: begin
            random_name(nm, n);
            push_name(nm, n);
            push_s("\t");
            push_s(rand_pos());
         end
         6: begin
            push_s("*");
            if ($urandom_range(0, 1)) push_s("x");
            push_s("\t");
            push_s($urandom_range(0, 1) ? rand_pos() : "0");
         end
         7: begin
            push_name(known_names[k], known_lens[k]);
            push_s("\t0");
         end
         8: begin
            push_name(known_names[k], known_lens[k]);
            push_s("\t");
            push_s($urandom_range(0, 1) ? "99999999999999999" : "1099511627775");
         end
         default: begin
            push_name(known_names[k], known_lens[k]);
            push_s("\t");
            push_s(rand_pos());
         end
      endcase
      // trailing junk after the number, or more tab fields
      if ($urandom_range(0, 3) == 0) push_s("ab");
      if ($urandom_range(0, 1)) begin
         push_s("\t");
         repeat ($urandom_range(0, 12)) text_q.push_back(noise_byte());
      end
      text_q.push_back(slpr_pkg::CH_NL);
   endfunction

   function automatic void build_header();
      bit [319:0] nm;
      int         n;
      push_s("@HD\tVN:1.6\n");
      push_s("@SR\tSN:q\tLN:3\n");
      push_s("@\n");
      sq_line({288'd0, "Arhc"}, 4, "1000");
      sq_line({288'd0, "Brhc"}, 4, "250x9");
      sq_line('0, 0, "77");
      nm = '0;
      for (int i = 0; i < 40; i++) nm[i*8 +: 8] = 8'(8'h61 + i % 26);
      sq_line(nm, 40, "5");
      // same name again: lookups must pick this newer entry
      sq_line({288'd0, "Arhc"}, 4, "30");
      push_s("@SQ\tSN:noLen\n");
      known_names.push_back({280'd0, "neLon"});
      known_lens.push_back(5);
      while (known_names.size() < HDR_REFS) begin
         if ($urandom_range(0, 7) == 0) begin
            push_s("@CO\t");
            repeat ($urandom_range(0, 20)) text_q.push_back(noise_byte());
            text_q.push_back(slpr_pkg::CH_NL);
         end
         random_name(nm, n);
         sq_line(nm, n, $sformatf("%0d", {$urandom_range(0, 1), $urandom}));
      end
      random_name(nm, n);
      sq_line(nm, n, "99999999999999");
      random_name(nm, n);
      sq_line(nm, n, "12");
      random_name(nm, n);
      sq_line(nm, n, "99999999999999");
      push_s("@PG\tID:x\n");
   endfunction

   task automatic wait_idle();
      do @(negedge clock); while (text_q.size() != 0 || req_valid || line_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_sinks(bit [slpr_pkg::CSR_W-1:0] v);
      csr_valid <= 1'b1;
      csr_sink_count <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sinks_cfg = v;
   endtask

   initial begin
      bit [slpr_pkg::CSR_W-1:0] settings [6];
      settings = '{11'd0, 11'd2047, 11'd1024, 11'd1, 11'd3, 11'd0};
      settings[5] = slpr_pkg::CSR_W'($urandom_range(2, 1023));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_sinks(slpr_pkg::CSR_W'($urandom_range(2, 1024)));
      @(negedge clock);
      build_header();
      for (int p = 0; p < 9; p++) align_line(p);
      for (int v = 0; v < 5; v++) align_line(9);
      for (int i = 0; i < 3; i++) align_line($urandom_range(0, 9));
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         write_sinks(settings[ph]);
         @(negedge clock);
         gaps_on = (ph % 2) != 0;
         for (int i = 0; i < 3; i++) align_line($urandom_range(0, 9));
      end
      wait_idle();
      if (errors == 0 && line_results.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
